>>> src/csh_pkg.sv
// shared types, constants and step codes of the colour sensor hsl filter
`timescale 1ns / 1ps
package csh_pkg;

  // default sizes
  localparam int MEDIAN_WINDOW_DEF = 5;
  localparam int AVERAGE_DEPTH_DEF = 8;

  // field widths
  localparam int CH_W   = 8;
  localparam int HUE_W  = 9;
  localparam int SAT_W  = 7;
  localparam int LIG_W  = 7;
  localparam int HSL_W  = HUE_W + SAT_W + LIG_W;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 9;

  // shared divider widths
  localparam int DVD_W = 17;
  localparam int DVS_W = 8;
  localparam int DCNT_W = 5;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_RED_LOW   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RED_HIGH  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GRN_LOW   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GRN_HIGH  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BLU_LOW   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_BLU_HIGH  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_HUE_LIMIT = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SAT_LIMIT = 3'd7;

  // register reset values
  localparam logic [CH_W-1:0]  RED_LOW_RST   = 8'd25;
  localparam logic [CH_W-1:0]  RED_HIGH_RST  = 8'd54;
  localparam logic [CH_W-1:0]  GRN_LOW_RST   = 8'd15;
  localparam logic [CH_W-1:0]  GRN_HIGH_RST  = 8'd100;
  localparam logic [CH_W-1:0]  BLU_LOW_RST   = 8'd10;
  localparam logic [CH_W-1:0]  BLU_HIGH_RST  = 8'd90;
  localparam logic [HUE_W-1:0] HUE_LIMIT_RST = 9'd360;
  localparam logic [SAT_W-1:0] SAT_LIMIT_RST = 7'd101;

  // divider steps of one request
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_MAP_R = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MAP_G = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAP_B = 4'd2;
  localparam logic [STEP_W-1:0] STEP_HUE   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SAT   = 4'd4;

  // controller to datapath
  typedef struct packed {
    logic              load_in;
    logic              div_start;
    logic [STEP_W-1:0] step;
    logic              capture;
    logic              med_step;
    logic              hist_read;
    logic              hist_write;
    logic              out_load;
  } csh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic window_full;
    logic med_last;
    logic out_free;
  } csh_status_t;

endpackage

>>> src/color_sensor_hsl_filter_top.sv
// top level of the colour sensor hsl filter
//
//   channel  handshake              payload
//   in       in_valid / in_ready    raw_red, raw_green, raw_blue
//   out      out_valid / out_ready  hue_avg, saturation_avg, lightness_avg
//   cfg      cfg_we                 cfg_addr, cfg_wdata
//
// every division runs on the shared 17-bit serial divider
// a request takes three calibration divisions; the one closing a
// median window adds a median pass and the hue and saturation divisions
// lightness and averages come from constant reciprocal multiplies
// reset is synchronous; the history ring reads as zero until written
// a held result stalls only the request that would replace it
`timescale 1ns / 1ps
module color_sensor_hsl_filter_top #(
  parameter int MEDIAN_WINDOW = csh_pkg::MEDIAN_WINDOW_DEF,
  parameter int AVERAGE_DEPTH = csh_pkg::AVERAGE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [csh_pkg::CH_W-1:0]   raw_red,
  input  logic [csh_pkg::CH_W-1:0]   raw_green,
  input  logic [csh_pkg::CH_W-1:0]   raw_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [csh_pkg::HUE_W-1:0]  hue_avg,
  output logic [csh_pkg::SAT_W-1:0]  saturation_avg,
  output logic [csh_pkg::LIG_W-1:0]  lightness_avg,
  input  logic                       cfg_we,
  input  logic [csh_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [csh_pkg::CFG_DW-1:0] cfg_wdata
);
  import csh_pkg::*;

  csh_cmd_t    cmd;
  csh_status_t status;

  // controller
  csh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath
  csh_datapath #(
    .MEDIAN_WINDOW (MEDIAN_WINDOW),
    .AVERAGE_DEPTH (AVERAGE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .raw_red        (raw_red),
    .raw_green      (raw_green),
    .raw_blue       (raw_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hue_avg        (hue_avg),
    .saturation_avg (saturation_avg),
    .lightness_avg  (lightness_avg)
  );

endmodule

>>> src/csh_divider.sv
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module csh_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [csh_pkg::DVD_W-1:0] dividend,
  input  logic [csh_pkg::DVS_W-1:0] divisor,
  output logic [csh_pkg::DVD_W-1:0] quotient,
  output logic                      done
);
  import csh_pkg::*;

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [DVS_W:0]    rem_s;
  logic              ge;
  logic [DVS_W:0]    rem_d;

  // trial subtract
  always_comb begin
    rem_s = {rem, quo[DVD_W-1]};
    ge    = rem_s >= {1'b0, dsr};
    rem_d = ge ? rem_s - {1'b0, dsr} : rem_s;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= rem_d[DVS_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

>>> src/csh_datapath.sv
// datapath: calibration, capture buffer, median, hsl, history ring and output
`timescale 1ns / 1ps
module csh_datapath #(
  parameter int MEDIAN_WINDOW = csh_pkg::MEDIAN_WINDOW_DEF,
  parameter int AVERAGE_DEPTH = csh_pkg::AVERAGE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  csh_pkg::csh_cmd_t          cmd,
  output csh_pkg::csh_status_t       status,
  input  logic                       cfg_we,
  input  logic [csh_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [csh_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic [csh_pkg::CH_W-1:0]   raw_red,
  input  logic [csh_pkg::CH_W-1:0]   raw_green,
  input  logic [csh_pkg::CH_W-1:0]   raw_blue,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [csh_pkg::HUE_W-1:0]  hue_avg,
  output logic [csh_pkg::SAT_W-1:0]  saturation_avg,
  output logic [csh_pkg::LIG_W-1:0]  lightness_avg
);
  import csh_pkg::*;

  localparam int CAP_W  = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MEDIAN_WINDOW + 1);
  localparam int MID    = MEDIAN_WINDOW / 2;
  localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int HS_W   = HUE_W + $clog2(AVERAGE_DEPTH);
  localparam int SS_W   = SAT_W + $clog2(AVERAGE_DEPTH);
  localparam int LS_W   = LIG_W + $clog2(AVERAGE_DEPTH);

  // reciprocal of the ring depth, exact for every reachable sum
  localparam int AVG_SH = 22;
  localparam int RCP_W  = AVG_SH + 1;
  localparam longint AVG_RCP_L =
    ((longint'(1) << AVG_SH) + longint'(AVERAGE_DEPTH) - longint'(1)) /
    longint'(AVERAGE_DEPTH);
  localparam logic [RCP_W-1:0] AVG_RCP = RCP_W'(AVG_RCP_L);

  // configuration registers
  logic [CH_W-1:0]  lo_cal [3];
  logic [CH_W-1:0]  hi_cal [3];
  logic [HUE_W-1:0] hue_limit;
  logic [SAT_W-1:0] sat_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_cal[0] <= RED_LOW_RST;
      hi_cal[0] <= RED_HIGH_RST;
      lo_cal[1] <= GRN_LOW_RST;
      hi_cal[1] <= GRN_HIGH_RST;
      lo_cal[2] <= BLU_LOW_RST;
      hi_cal[2] <= BLU_HIGH_RST;
      hue_limit <= HUE_LIMIT_RST;
      sat_limit <= SAT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RED_LOW:   lo_cal[0] <= cfg_wdata[CH_W-1:0];
        REG_RED_HIGH:  hi_cal[0] <= cfg_wdata[CH_W-1:0];
        REG_GRN_LOW:   lo_cal[1] <= cfg_wdata[CH_W-1:0];
        REG_GRN_HIGH:  hi_cal[1] <= cfg_wdata[CH_W-1:0];
        REG_BLU_LOW:   lo_cal[2] <= cfg_wdata[CH_W-1:0];
        REG_BLU_HIGH:  hi_cal[2] <= cfg_wdata[CH_W-1:0];
        REG_HUE_LIMIT: hue_limit <= cfg_wdata[HUE_W-1:0];
        REG_SAT_LIMIT: sat_limit <= cfg_wdata[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // input request
  logic [CH_W-1:0] raw [3];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw[0] <= raw_red;
      raw[1] <= raw_green;
      raw[2] <= raw_blue;
    end
  end

  // shared divider
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic             div_done;

  csh_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (div_done)
  );

  // linear map of the selected channel
  logic [1:0]      ch;
  logic [CH_W-1:0] m_raw, m_lo, m_hi;
  logic [CH_W:0]   m_diff, m_span;
  logic [CH_W-1:0] m_adiff, m_aspan;
  logic [CH_W-1:0] m_val;

  always_comb begin
    ch      = cmd.step[1:0];
    m_raw   = raw[0];
    m_lo    = lo_cal[0];
    m_hi    = hi_cal[0];
    case (ch)
      2'd1: begin
        m_raw = raw[1];
        m_lo  = lo_cal[1];
        m_hi  = hi_cal[1];
      end
      2'd2: begin
        m_raw = raw[2];
        m_lo  = lo_cal[2];
        m_hi  = hi_cal[2];
      end
      default: ;
    endcase
    m_diff  = {1'b0, m_raw} - {1'b0, m_lo};
    m_span  = {1'b0, m_hi} - {1'b0, m_lo};
    m_adiff = m_diff[CH_W] ? CH_W'(-m_diff) : m_diff[CH_W-1:0];
    m_aspan = m_span[CH_W] ? CH_W'(-m_span) : m_span[CH_W-1:0];
    // equal calibration, then opposite signs push past full scale
    if (m_span == '0) begin
      m_val = (m_raw <= m_lo) ? 8'd255 : 8'd0;
    end else if (m_diff[CH_W] != m_span[CH_W]) begin
      m_val = 8'd255;
    end else if (quo > DVD_W'(255)) begin
      m_val = 8'd0;
    end else begin
      m_val = 8'd255 - quo[CH_W-1:0];
    end
  end

  // last channel values and capture buffer
  logic [CH_W-1:0]  last [3];
  logic [CH_W-1:0]  cap  [3][MEDIAN_WINDOW];
  logic [CAP_W-1:0] cap_cnt;
  logic [CAP_W-1:0] med_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      last[0] <= '0;
      last[1] <= '0;
      last[2] <= '0;
      cap_cnt <= '0;
      med_idx <= '0;
    end else begin
      if (div_done && cmd.step <= STEP_MAP_B && m_raw != '0) begin
        last[ch] <= m_val;
      end
      if (cmd.capture) begin
        med_idx <= '0;
        if (cap_cnt == CAP_W'(MEDIAN_WINDOW - 1)) begin
          cap_cnt <= '0;
        end else begin
          cap_cnt <= cap_cnt + 1'b1;
        end
      end else if (cmd.med_step) begin
        med_idx <= med_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap[0][cap_cnt] <= last[0];
      cap[1][cap_cnt] <= last[1];
      cap[2][cap_cnt] <= last[2];
    end
  end

  // median by rank of one candidate per cycle
  logic [CH_W-1:0]  cand   [3];
  logic [CNT_W-1:0] n_lt   [3];
  logic [CNT_W-1:0] n_le   [3];
  logic [2:0]       is_med;
  logic [CH_W-1:0]  med    [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cand[c] = cap[c][med_idx];
      n_lt[c] = '0;
      n_le[c] = '0;
      for (int j = 0; j < MEDIAN_WINDOW; j++) begin
        n_lt[c] = n_lt[c] + CNT_W'(cap[c][j] < cand[c]);
        n_le[c] = n_le[c] + CNT_W'(cap[c][j] <= cand[c]);
      end
      is_med[c] = (n_lt[c] <= CNT_W'(MID)) && (n_le[c] > CNT_W'(MID));
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.med_step && is_med[c]) begin
        med[c] <= cand[c];
      end
    end
  end

  // hue numerator, spread and maximum
  logic [CH_W-1:0] mx, mn, dd;
  logic [1:0]      mx_idx;
  logic [CH_W:0]   h_t;
  logic [9:0]      h_off;
  logic [11:0]     h_sum;
  logic [17:0]     h_num, h_adj;

  always_comb begin
    mx     = med[0];
    mx_idx = 2'd0;
    if (med[1] > mx) begin
      mx     = med[1];
      mx_idx = 2'd1;
    end
    if (med[2] > mx) begin
      mx     = med[2];
      mx_idx = 2'd2;
    end
    mn = med[0];
    if (med[1] < mn) mn = med[1];
    if (med[2] < mn) mn = med[2];
    dd = mx - mn;
    case (mx_idx)
      2'd1: begin
        h_t   = {1'b0, med[2]} - {1'b0, med[0]};
        h_off = {1'b0, dd, 1'b0};
      end
      2'd2: begin
        h_t   = {1'b0, med[0]} - {1'b0, med[1]};
        h_off = {dd, 2'b00};
      end
      default: begin
        h_t   = {1'b0, med[1]} - {1'b0, med[2]};
        h_off = '0;
      end
    endcase
    h_sum = {2'b00, h_off} + {{3{h_t[CH_W]}}, h_t};
    h_num = {{6{h_sum[11]}}, h_sum} * 18'd60;
    h_adj = h_num[17] ? h_num + 18'(dd) * 18'd360 : h_num;
  end

  // hsl of the window
  logic [HUE_W-1:0] hue_v;
  logic [SAT_W-1:0] sat_v;
  logic [LIG_W-1:0] lig_v;
  logic [14:0]      lig_x;
  logic [15:0]      lig_t;

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.step)
        STEP_HUE: begin
          if (dd == '0 || quo[HUE_W-1:0] >= hue_limit) begin
            hue_v <= '0;
          end else begin
            hue_v <= quo[HUE_W-1:0];
          end
        end
        STEP_SAT: begin
          if (mx == '0 || quo[SAT_W-1:0] >= sat_limit) begin
            sat_v <= '0;
          end else begin
            sat_v <= quo[SAT_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // lightness: 100 * max / 255 by folding the high byte back in
  always_comb begin
    lig_x = 15'(mx) * 15'd100;
    lig_t = 16'(lig_x) + 16'(lig_x[14:8]) + 16'd1;
    lig_v = lig_t[8 +: LIG_W];
  end

  // history ring with running sums
  logic [HSL_W-1:0]  hist [AVERAGE_DEPTH];
  logic [AVERAGE_DEPTH-1:0] hist_vld;
  logic [HSL_W-1:0]  hist_q;
  logic              old_vld;
  logic [SLOT_W-1:0] slot;
  logic [HS_W-1:0]   sum_h;
  logic [SS_W-1:0]   sum_s;
  logic [LS_W-1:0]   sum_l;
  logic [HSL_W-1:0]  old_e;

  assign old_e = old_vld ? hist_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.hist_read) begin
      hist_q <= hist[slot];
    end
    if (cmd.hist_write) begin
      hist[slot] <= {hue_v, sat_v, lig_v};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      old_vld  <= 1'b0;
      slot     <= '0;
      sum_h    <= '0;
      sum_s    <= '0;
      sum_l    <= '0;
    end else begin
      if (cmd.hist_read) begin
        old_vld <= hist_vld[slot];
      end
      if (cmd.hist_write) begin
        hist_vld[slot] <= 1'b1;
        sum_h <= sum_h - HS_W'(old_e[HSL_W-1 -: HUE_W]) + HS_W'(hue_v);
        sum_s <= sum_s - SS_W'(old_e[LIG_W +: SAT_W]) + SS_W'(sat_v);
        sum_l <= sum_l - LS_W'(old_e[LIG_W-1:0]) + LS_W'(lig_v);
        if (slot == SLOT_W'(AVERAGE_DEPTH - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
    end
  end

  // averages by reciprocal multiply of the running sums
  logic [HS_W+RCP_W-1:0] avg_ph;
  logic [SS_W+RCP_W-1:0] avg_ps;
  logic [LS_W+RCP_W-1:0] avg_pl;
  logic [HUE_W-1:0]      avg_h;
  logic [SAT_W-1:0]      avg_s;
  logic [LIG_W-1:0]      avg_l;

  always_comb begin
    avg_ph = (HS_W+RCP_W)'(sum_h) * (HS_W+RCP_W)'(AVG_RCP);
    avg_ps = (SS_W+RCP_W)'(sum_s) * (SS_W+RCP_W)'(AVG_RCP);
    avg_pl = (LS_W+RCP_W)'(sum_l) * (LS_W+RCP_W)'(AVG_RCP);
    avg_h  = avg_ph[AVG_SH +: HUE_W];
    avg_s  = avg_ps[AVG_SH +: SAT_W];
    avg_l  = avg_pl[AVG_SH +: LIG_W];
  end

  // divider operands per step
  always_comb begin
    dvd = '0;
    dvs = '0;
    case (cmd.step)
      STEP_MAP_R, STEP_MAP_G, STEP_MAP_B: begin
        dvd = DVD_W'(m_adiff) * DVD_W'(255);
        dvs = m_aspan;
      end
      STEP_HUE: begin
        dvd = h_adj[DVD_W-1:0];
        dvs = dd;
      end
      STEP_SAT: begin
        dvd = DVD_W'(dd) * DVD_W'(100);
        dvs = mx;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hue_avg        <= avg_h;
      saturation_avg <= avg_s;
      lightness_avg  <= avg_l;
    end
  end

  // status
  always_comb begin
    status.div_done    = div_done;
    status.window_full = cap_cnt == CAP_W'(MEDIAN_WINDOW - 1);
    status.med_last    = med_idx == CAP_W'(MEDIAN_WINDOW - 1);
    status.out_free    = !out_valid || out_ready;
  end

endmodule

>>> src/csh_ctrl.sv
// controller: sequences divisions, capture, median, history and output
`timescale 1ns / 1ps
module csh_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output csh_pkg::csh_cmd_t    cmd,
  input  csh_pkg::csh_status_t status
);
  import csh_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT  = 3'd2;
  localparam logic [2:0] S_CAPT   = 3'd3;
  localparam logic [2:0] S_MED    = 3'd4;
  localparam logic [2:0] S_HRD    = 3'd5;
  localparam logic [2:0] S_HWR    = 3'd6;
  localparam logic [2:0] S_OUTW   = 3'd7;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  assign in_ready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    cmd            = '0;
    cmd.step       = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          step_next   = STEP_MAP_R;
          state_next  = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          case (step)
            STEP_MAP_B: state_next = S_CAPT;
            STEP_SAT:   state_next = S_HRD;
            default: begin
              step_next  = step + 1'b1;
              state_next = S_DSTART;
            end
          endcase
        end
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = status.window_full ? S_MED : S_IDLE;
      end
      S_MED: begin
        cmd.med_step = 1'b1;
        if (status.med_last) begin
          step_next  = STEP_HUE;
          state_next = S_DSTART;
        end
      end
      S_HRD: begin
        cmd.hist_read = 1'b1;
        state_next    = S_HWR;
      end
      S_HWR: begin
        cmd.hist_write = 1'b1;
        state_next     = S_OUTW;
      end
      S_OUTW: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= STEP_MAP_R;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> test/color_sensor_hsl_filter_top_test.sv
// testbench of the colour sensor hsl filter: directed and random requests against a predictor
`timescale 1ns / 1ps
module color_sensor_hsl_filter_top_test;
  import csh_pkg::*;

  localparam int WINDOW     = MEDIAN_WINDOW_DEF;
  localparam int DEPTH      = AVERAGE_DEPTH_DEF;
  localparam int SETTLE     = 300;
  localparam int HOLD_LONG  = 3000;
  localparam int CYCLE_CAP  = 2000000;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 105;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic [LIG_W-1:0] lig;
  } hsl_t;

  typedef struct {
    logic [CH_W-1:0] r, g, b;
    bit              typed;
    hsl_t            avg;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CH_W-1:0] raw_red = '0, raw_green = '0, raw_blue = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [HUE_W-1:0] hue_avg;
  logic [SAT_W-1:0] saturation_avg;
  logic [LIG_W-1:0] lightness_avg;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  color_sensor_hsl_filter_top uut (.*);

  always #5 clk = ~clk;

  // calibration and limits as the block should hold them
  int cal_lo[3] = '{25, 15, 10};
  int cal_hi[3] = '{54, 100, 90};
  int hue_lim = 360;
  int sat_lim = 101;

  // filter state
  int last_ch[3] = '{0, 0, 0};
  int captures[WINDOW][3];
  int cap_count = 0;
  hsl_t history[DEPTH];
  int slot = 0;

  hsl_t pending_avg[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit no_gaps = 0;

  function automatic int map_pulse(int raw, int lo, int hi);
    int span, v;
    span = hi - lo;
    if (span == 0) return (raw <= lo) ? 255 : 0;
    v = 255 + ((raw - lo) * -255) / span;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic int median_of(int ch);
    int v[WINDOW];
    int t, j;
    for (int i = 0; i < WINDOW; i++) v[i] = captures[i][ch];
    // insertion sort, ascending
    for (int i = 1; i < WINDOW; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    return v[WINDOW/2];
  endfunction

  function automatic hsl_t hsl_of(int r, int g, int b);
    int mx, mn, idx, d, num, hue, sat;
    hsl_t res;
    mx = r; mn = r; idx = 0; hue = 0; sat = 0;
    if (g > mx) begin mx = g; idx = 1; end
    if (b > mx) begin mx = b; idx = 2; end
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d != 0) begin
      if (idx == 0) num = 60 * (g - b);
      else if (idx == 1) num = 60 * (2 * d + b - r);
      else num = 60 * (4 * d + r - g);
      if (num < 0) num += 360 * d;
      hue = num / d;
      if (hue >= hue_lim) hue = 0;
    end
    if (mx != 0) sat = 100 * d / mx;
    if (sat >= sat_lim) sat = 0;
    res.hue = hue[HUE_W-1:0];
    res.sat = sat[SAT_W-1:0];
    res.lig = 7'(100 * mx / 255);
    return res;
  endfunction

  // advance the filter by one capture; flags when a window closes
  task automatic filter_capture(input logic [CH_W-1:0] r, g, b, output bit done,
                                output hsl_t avg);
    int raw[3];
    int sh, ss, sl;
    raw = '{r, g, b};
    done = 0;
    avg = '0;
    for (int c = 0; c < 3; c++)
      if (raw[c] != 0) last_ch[c] = map_pulse(raw[c], cal_lo[c], cal_hi[c]);
    if (cap_count >= WINDOW) cap_count = 0;
    for (int c = 0; c < 3; c++) captures[cap_count][c] = last_ch[c];
    cap_count++;
    if (cap_count < WINDOW) return;
    cap_count = 0;
    history[slot] = hsl_of(median_of(0), median_of(1), median_of(2));
    slot = (slot + 1) % DEPTH;
    sh = 0; ss = 0; sl = 0;
    for (int i = 0; i < DEPTH; i++) begin
      sh += history[i].hue;
      ss += history[i].sat;
      sl += history[i].lig;
    end
    avg.hue = HUE_W'(sh / DEPTH);
    avg.sat = SAT_W'(ss / DEPTH);
    avg.lig = LIG_W'(sl / DEPTH);
    done = 1;
  endtask

  // offer one request, called and returning at a falling edge
  task automatic send_request(input stim_row_t row);
    int gap;
    bit done;
    hsl_t avg;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    raw_red   <= row.r;
    raw_green <= row.g;
    raw_blue  <= row.b;
    do @(posedge clk); while (!in_ready);
    filter_capture(row.r, row.g, row.b, done, avg);
    if (done) pending_avg.push_back(row.typed ? row.avg : avg);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input int data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DW'(data);
    @(negedge clk);
    case (addr)
      REG_RED_LOW:   cal_lo[0] = data & 8'hFF;
      REG_RED_HIGH:  cal_hi[0] = data & 8'hFF;
      REG_GRN_LOW:   cal_lo[1] = data & 8'hFF;
      REG_GRN_HIGH:  cal_hi[1] = data & 8'hFF;
      REG_BLU_LOW:   cal_lo[2] = data & 8'hFF;
      REG_BLU_HIGH:  cal_hi[2] = data & 8'hFF;
      REG_HUE_LIMIT: hue_lim = data & 9'h1FF;
      REG_SAT_LIMIT: sat_lim = data & 7'h7F;
      default: ;
    endcase
  endtask

  // stop offering and let the block drain, including a capture with no result
  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_avg.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic configure(input int lo[3], input int hi[3], input int hl, input int sl);
    write_reg(REG_RED_LOW, lo[0]);
    write_reg(REG_RED_HIGH, hi[0]);
    write_reg(REG_GRN_LOW, lo[1]);
    write_reg(REG_GRN_HIGH, hi[1]);
    write_reg(REG_BLU_LOW, lo[2]);
    write_reg(REG_BLU_HIGH, hi[2]);
    write_reg(REG_HUE_LIMIT, hl);
    write_reg(REG_SAT_LIMIT, sl);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // raw width: some timeouts, some anywhere, the rest around the calibrated span
  function automatic logic [CH_W-1:0] draw_raw(int c);
    int a, z, v;
    if ($urandom_range(0, 99) < 12) return '0;
    if ($urandom_range(0, 1) == 0) return CH_W'($urandom_range(1, 255));
    a = (cal_lo[c] < cal_hi[c]) ? cal_lo[c] : cal_hi[c];
    z = (cal_lo[c] < cal_hi[c]) ? cal_hi[c] : cal_lo[c];
    v = $urandom_range(a, z + 10);
    if (v < 1) v = 1;
    if (v > 255) v = 255;
    return CH_W'(v);
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_LONG) @(negedge clk);
        hold_off = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 9);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    hsl_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_avg.size() == 0) begin
        $display("%0t unexpected result hue %0d sat %0d lig %0d", $time,
                 hue_avg, saturation_avg, lightness_avg);
        errors++;
      end else begin
        want = pending_avg.pop_front();
        if (hue_avg !== want.hue) begin
          $display("%0t hue_avg expected %0d got %0d", $time, want.hue, hue_avg);
          errors++;
        end
        if (saturation_avg !== want.sat) begin
          $display("%0t saturation_avg expected %0d got %0d", $time, want.sat,
                   saturation_avg);
          errors++;
        end
        if (lightness_avg !== want.lig) begin
          $display("%0t lightness_avg expected %0d got %0d", $time, want.lig,
                   lightness_avg);
          errors++;
        end
      end
    end
  end

  // directed requests; every fifth closes a median window
  stim_row_t stim_rows[25] = '{
    // all timeouts from reset: black
    '{8'd0, 8'd0, 8'd0, 0, '0}, '{8'd0, 8'd0, 8'd0, 0, '0},
    '{8'd0, 8'd0, 8'd0, 0, '0}, '{8'd0, 8'd0, 8'd0, 0, '0},
    '{8'd0, 8'd0, 8'd0, 1, '{9'd0, 7'd0, 7'd0}},
    // shortest widths clamp to white
    '{8'd1, 8'd1, 8'd1, 0, '0}, '{8'd1, 8'd1, 8'd1, 0, '0},
    '{8'd1, 8'd1, 8'd1, 0, '0}, '{8'd1, 8'd1, 8'd1, 0, '0},
    '{8'd1, 8'd1, 8'd1, 1, '{9'd0, 7'd0, 7'd12}},
    // longest widths clamp to black
    '{8'd255, 8'd255, 8'd255, 0, '0}, '{8'd255, 8'd255, 8'd255, 0, '0},
    '{8'd255, 8'd255, 8'd255, 0, '0}, '{8'd255, 8'd255, 8'd255, 0, '0},
    '{8'd255, 8'd255, 8'd255, 1, '{9'd0, 7'd0, 7'd12}},
    // pure red, with a timeout keeping the previous values
    '{8'd25, 8'd100, 8'd90, 0, '0}, '{8'd0, 8'd0, 8'd0, 0, '0},
    '{8'd25, 8'd100, 8'd90, 0, '0}, '{8'd25, 8'd100, 8'd90, 0, '0},
    '{8'd25, 8'd100, 8'd90, 1, '{9'd0, 7'd12, 7'd25}},
    // pure green
    '{8'd54, 8'd15, 8'd90, 0, '0}, '{8'd54, 8'd15, 8'd90, 0, '0},
    '{8'd54, 8'd15, 8'd0, 0, '0}, '{8'd54, 8'd15, 8'd90, 0, '0},
    '{8'd54, 8'd15, 8'd90, 1, '{9'd15, 7'd25, 7'd37}}
  };

  initial begin
    int lo[3], hi[3];
    int hl, sl, eq;
    stim_row_t row;
    for (int i = 0; i < DEPTH; i++) history[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[i]) send_request(stim_rows[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      for (int c = 0; c < 3; c++) begin
        lo[c] = $urandom_range(0, 60);
        hi[c] = lo[c] + $urandom_range(1, 120);
      end
      hl = 360;
      sl = 101;
      case (p)
        1: begin lo = '{0, 0, 0}; hi = '{255, 255, 255}; hl = 511; sl = 127; end
        2: begin
          lo = '{255, 200, 255}; hi = '{0, 30, 100};
          hl = $urandom_range(0, 511); sl = $urandom_range(0, 127);
        end
        3: begin
          // equal calibration on every channel, both limits at zero
          for (int c = 0; c < 3; c++) begin
            eq = $urandom_range(0, 255);
            lo[c] = eq; hi[c] = eq;
          end
          hl = 0; sl = 0;
        end
        4: begin
          for (int c = 0; c < 3; c++) begin
            lo[c] = $urandom_range(0, 255); hi[c] = $urandom_range(0, 255);
          end
          hl = $urandom_range(0, 511); sl = $urandom_range(0, 127);
        end
        5: begin
          lo = '{RED_LOW_RST, GRN_LOW_RST, BLU_LOW_RST};
          hi = '{RED_HIGH_RST, GRN_HIGH_RST, BLU_HIGH_RST};
          hl = HUE_LIMIT_RST; sl = SAT_LIMIT_RST;
        end
        6: begin hl = $urandom_range(0, 511); sl = $urandom_range(0, 127); end
        7: begin lo = '{255, 0, 128}; hi = '{255, 0, 128}; hl = 359; sl = 50; end
        default: ;
      endcase
      configure(lo, hi, hl, sl);
      // long receiver hold-off while requests keep coming; a stretch with no idling
      if (p == 2) hold_off = 1;
      no_gaps = (p == 4);
      for (int n = 0; n < PHASE_REQS; n++) begin
        row.r = draw_raw(0);
        row.g = draw_raw(1);
        row.b = draw_raw(2);
        row.typed = 0;
        row.avg = '0;
        send_request(row);
      end
    end

    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
